// ----- rtl/core/vpa_pkg.sv -----
// Shared types and constants of the variable partition allocator.
`timescale 1ns / 1ps
package vpa_pkg;

  localparam int MAX_PARTS = 64;
  localparam int AW        = $clog2(MAX_PARTS);
  localparam int CW        = $clog2(MAX_PARTS + 1);
  localparam int DW        = 17;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_FREE    = 1'b1;
  localparam logic CFG_TOTAL  = 1'b0;
  localparam logic CFG_POLICY = 1'b1;
  localparam logic FIT_FIRST  = 1'b0;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOFIT   = 3'd1,
    ST_BADSIZE = 3'd2,
    ST_NOPART  = 3'd3,
    ST_ISFREE  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ASCAN, S_ADEC, S_ASHIFT, S_AWR0, S_AWR1,
    S_FRD, S_FCHK, S_FSHIFT, S_DONE
  } state_t;

  typedef struct packed {
    logic [DW-1:0] start;
    logic [DW-1:0] size;
    logic          busy;
  } entry_t;

endpackage

// ----- rtl/core/variable_partition_allocator.sv -----
// Variable partition allocator: top level with table RAM and sequencer.
// One request at a time. Allocate scans the table one entry a cycle through the
// RAM read port (first fit stops at the first free entry large enough); a split
// then shifts the entries above the hole up one a cycle. Free reads the entry
// and both neighbours and, on a merge, shifts the entries above down one a
// cycle. A write of total_size rebuilds the table as one free partition at
// address 0, written once the sequencer is idle; entry 0 is also written after
// reset, and no word is taken while that write is pending. Results wait in an
// output register while the next word is being worked on.
`timescale 1ns / 1ps
module variable_partition_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [16:0] in_request_size,
  input  logic [5:0]  in_partition_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [16:0] out_block_address,
  output logic [5:0]  out_block_index
);

  localparam int AW = vpa_pkg::AW;
  localparam int CW = vpa_pkg::CW;
  localparam int DW = vpa_pkg::DW;

  vpa_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [DW-1:0]    total_r;
  logic             policy_r;
  logic             init_pend_r;
  logic [DW-1:0]    req_r, req_nxt;
  logic [5:0]       k_r, k_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]    pidx_r, pidx_nxt;
  logic             pend_r, pend_nxt;
  logic             found_r, found_nxt;
  logic [CW-1:0]    pick_r, pick_nxt;
  logic [DW-1:0]    pick_start_r, pick_start_nxt;
  logic [DW-1:0]    pick_size_r, pick_size_nxt;
  logic [1:0]       step_r, step_nxt;
  vpa_pkg::entry_t  cur_r, cur_nxt, prev_r, prev_nxt, next_r, next_nxt;
  logic [1:0]       shift_r, shift_nxt;
  vpa_pkg::status_t res_status_r, res_status_nxt;
  logic [DW-1:0]    res_addr_r, res_addr_nxt;
  logic [5:0]       res_idx_r, res_idx_nxt;
  logic             out_valid_r;
  logic [2:0]       out_status_r;
  logic [DW-1:0]    out_addr_r;
  logic [5:0]       out_idx_r;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  vpa_pkg::entry_t  ram_wdata, ram_rdata;

  logic             accept, out_free, hit, scan_done, shift_done, fshift_done;
  logic             pf, nf;
  logic [CW-1:0]    k_ext;

  vpa_ram #(.WIDTH($bits(vpa_pkg::entry_t)), .DEPTH(vpa_pkg::MAX_PARTS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept      = in_valid && !in_stall;
  assign in_stall    = (state_r != vpa_pkg::S_IDLE) || init_pend_r;
  assign out_free    = !out_valid_r || !out_stall;
  assign hit         = !ram_rdata.busy && (ram_rdata.size >= req_r);
  assign scan_done   = (policy_r == vpa_pkg::FIT_FIRST && found_r) ||
                       (!pend_r && idx_r >= count_r);
  assign shift_done  = !pend_r && idx_r <= pick_r;
  assign fshift_done = !pend_r && idx_r >= count_r;
  assign k_ext       = CW'(k_r);
  assign pf          = (k_r != '0) && !prev_r.busy;
  assign nf          = (k_ext + CW'(1) < count_r) && !next_r.busy;

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_block_address = out_addr_r;
  assign out_block_index   = out_idx_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vpa_pkg::S_IDLE: begin
        if (accept) begin
          if (in_opcode == vpa_pkg::OP_ALLOC) begin
            state_nxt = (in_request_size == '0) ? vpa_pkg::S_DONE : vpa_pkg::S_ASCAN;
          end else begin
            state_nxt = (CW'(in_partition_index) >= count_r) ? vpa_pkg::S_DONE
                                                              : vpa_pkg::S_FRD;
          end
        end
      end
      vpa_pkg::S_ASCAN: if (scan_done) state_nxt = vpa_pkg::S_ADEC;
      vpa_pkg::S_ADEC: begin
        if (!found_r || (pick_size_r != req_r && count_r == CW'(vpa_pkg::MAX_PARTS))) begin
          state_nxt = vpa_pkg::S_DONE;
        end else if (pick_size_r == req_r) begin
          state_nxt = vpa_pkg::S_DONE;
        end else begin
          state_nxt = vpa_pkg::S_ASHIFT;
        end
      end
      vpa_pkg::S_ASHIFT: if (shift_done) state_nxt = vpa_pkg::S_AWR0;
      vpa_pkg::S_AWR0:   state_nxt = vpa_pkg::S_AWR1;
      vpa_pkg::S_AWR1:   state_nxt = vpa_pkg::S_DONE;
      vpa_pkg::S_FRD:    if (step_r == 2'd3) state_nxt = vpa_pkg::S_FCHK;
      vpa_pkg::S_FCHK:   state_nxt = cur_r.busy ? vpa_pkg::S_FSHIFT : vpa_pkg::S_DONE;
      vpa_pkg::S_FSHIFT: if (fshift_done) state_nxt = vpa_pkg::S_DONE;
      vpa_pkg::S_DONE:   if (out_free) state_nxt = vpa_pkg::S_IDLE;
      default:           state_nxt = vpa_pkg::S_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    count_nxt      = count_r;
    req_nxt        = req_r;
    k_nxt          = k_r;
    idx_nxt        = idx_r;
    pidx_nxt       = pidx_r;
    pend_nxt       = pend_r;
    found_nxt      = found_r;
    pick_nxt       = pick_r;
    pick_start_nxt = pick_start_r;
    pick_size_nxt  = pick_size_r;
    step_nxt       = step_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    next_nxt       = next_r;
    shift_nxt      = shift_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    res_idx_nxt    = res_idx_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = idx_r[AW-1:0];
    unique case (state_r)
      vpa_pkg::S_IDLE: begin
        if (init_pend_r) begin
          // rebuild: one free partition at address 0
          ram_we         = 1'b1;
          ram_wdata.size = total_r;
        end
        if (accept) begin
          req_nxt        = in_request_size;
          k_nxt          = in_partition_index;
          idx_nxt        = '0;
          pend_nxt       = 1'b0;
          found_nxt      = 1'b0;
          step_nxt       = '0;
          res_addr_nxt   = '0;
          res_idx_nxt    = '0;
          res_status_nxt = vpa_pkg::ST_OK;
          if (in_opcode == vpa_pkg::OP_ALLOC) begin
            if (in_request_size == '0) res_status_nxt = vpa_pkg::ST_BADSIZE;
          end else if (CW'(in_partition_index) >= count_r) begin
            res_status_nxt = vpa_pkg::ST_NOPART;
          end
        end
      end
      vpa_pkg::S_ASCAN: begin
        if (pend_r && !(policy_r == vpa_pkg::FIT_FIRST && found_r) && hit) begin
          if (!found_r || ram_rdata.size < pick_size_r) begin
            pick_nxt       = pidx_r;
            pick_start_nxt = ram_rdata.start;
            pick_size_nxt  = ram_rdata.size;
          end
          found_nxt = 1'b1;
        end
        if (idx_r < count_r) begin
          pidx_nxt = idx_r;
          idx_nxt  = idx_r + CW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
      end
      vpa_pkg::S_ADEC: begin
        if (!found_r || (pick_size_r != req_r && count_r == CW'(vpa_pkg::MAX_PARTS))) begin
          res_status_nxt = vpa_pkg::ST_NOFIT;
        end else if (pick_size_r == req_r) begin
          ram_we          = 1'b1;
          ram_waddr       = pick_r[AW-1:0];
          ram_wdata.start = pick_start_r;
          ram_wdata.size  = req_r;
          ram_wdata.busy  = 1'b1;
          res_addr_nxt    = pick_start_r;
          res_idx_nxt     = pick_r[5:0];
        end else begin
          idx_nxt  = count_r - CW'(1);
          pend_nxt = 1'b0;
        end
      end
      vpa_pkg::S_ASHIFT: begin
        // move entries above the hole up by one, top first
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(pidx_r + CW'(1));
          ram_wdata = ram_rdata;
        end
        if (idx_r > pick_r) begin
          pidx_nxt = idx_r;
          idx_nxt  = idx_r - CW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
      end
      vpa_pkg::S_AWR0: begin
        ram_we          = 1'b1;
        ram_waddr       = pick_r[AW-1:0];
        ram_wdata.start = pick_start_r;
        ram_wdata.size  = req_r;
        ram_wdata.busy  = 1'b1;
      end
      vpa_pkg::S_AWR1: begin
        ram_we          = 1'b1;
        ram_waddr       = AW'(pick_r + CW'(1));
        ram_wdata.start = pick_start_r + req_r;
        ram_wdata.size  = pick_size_r - req_r;
        count_nxt       = count_r + CW'(1);
        res_addr_nxt    = pick_start_r;
        res_idx_nxt     = pick_r[5:0];
      end
      vpa_pkg::S_FRD: begin
        step_nxt = step_r + 2'd1;
        unique case (step_r)
          2'd0: ram_raddr = AW'(k_r);
          2'd1: begin
            ram_raddr = AW'(k_r - 6'd1);
            cur_nxt   = ram_rdata;
          end
          2'd2: begin
            ram_raddr = AW'(k_r + 6'd1);
            prev_nxt  = ram_rdata;
          end
          default: next_nxt = ram_rdata;
        endcase
      end
      vpa_pkg::S_FCHK: begin
        if (!cur_r.busy) begin
          res_status_nxt = vpa_pkg::ST_ISFREE;
        end else begin
          ram_we          = 1'b1;
          ram_waddr       = AW'(k_r - {5'd0, pf});
          ram_wdata.start = pf ? prev_r.start : cur_r.start;
          ram_wdata.size  = cur_r.size + (pf ? prev_r.size : '0) + (nf ? next_r.size : '0);
          ram_wdata.busy  = 1'b0;
          shift_nxt       = {1'b0, pf} + {1'b0, nf};
          idx_nxt         = k_ext + CW'(1) + CW'(nf);
          pend_nxt        = 1'b0;
        end
      end
      vpa_pkg::S_FSHIFT: begin
        // close the gap left by merged entries, bottom first
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(pidx_r - CW'(shift_r));
          ram_wdata = ram_rdata;
        end
        if (idx_r < count_r) begin
          pidx_nxt = idx_r;
          idx_nxt  = idx_r + CW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (fshift_done) count_nxt = count_r - CW'(shift_r);
      end
      vpa_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase
    if (cfg_wr_en && cfg_index == vpa_pkg::CFG_TOTAL) count_nxt = CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vpa_pkg::S_IDLE;
      count_r     <= CW'(1);
      total_r     <= DW'(1024);
      policy_r    <= vpa_pkg::FIT_FIRST;
      init_pend_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_wr_en && cfg_index == vpa_pkg::CFG_TOTAL) begin
        init_pend_r <= 1'b1;
      end else if (state_r == vpa_pkg::S_IDLE && init_pend_r) begin
        init_pend_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        if (cfg_index == vpa_pkg::CFG_TOTAL) begin
          total_r <= cfg_data;
        end else begin
          policy_r <= cfg_data[0];
        end
      end
      if (state_r == vpa_pkg::S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    k_r          <= k_nxt;
    idx_r        <= idx_nxt;
    pidx_r       <= pidx_nxt;
    pend_r       <= pend_nxt;
    found_r      <= found_nxt;
    pick_r       <= pick_nxt;
    pick_start_r <= pick_start_nxt;
    pick_size_r  <= pick_size_nxt;
    step_r       <= step_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    next_r       <= next_nxt;
    shift_r      <= shift_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    res_idx_r    <= res_idx_nxt;
    if (state_r == vpa_pkg::S_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
      out_idx_r    <= res_idx_r;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != '0 && count_r <= CW'(vpa_pkg::MAX_PARTS))
    else $error("partition count out of range");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != vpa_pkg::S_IDLE)
    else $error("accepted word not worked on");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == vpa_pkg::S_DONE))
    else $error("result produced outside completion");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == vpa_pkg::S_ASCAN |-> !ram_we)
    else $error("table written during scan");

endmodule

// ----- rtl/core/vpa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module vpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench of the variable partition allocator.
`timescale 1ns / 1ps
module tb_top;

  localparam int STALL_LIMIT = 6000;
  localparam int SETTLE      = 300;

  typedef struct {
    logic        op;
    logic [16:0] req;
    logic [5:0]  idx;
  } word_t;

  typedef struct {
    vpa_pkg::status_t status;
    logic [16:0]      addr;
    logic [5:0]       idx;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = vpa_pkg::CFG_TOTAL;
  logic [16:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_opcode = vpa_pkg::OP_ALLOC;
  logic [16:0] in_request_size = '0;
  logic [5:0]  in_partition_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [16:0] out_block_address;
  logic [5:0]  out_block_index;

  word_t   pending[$];
  result_t expected[$];
  int      idle_pct = 0;
  int      stall_pct = 0;
  int      errors = 0;
  int      quiet = 0;
  logic    taken = 1'b0;

  // allocator table as the block should hold it
  logic [16:0] tbl_start[vpa_pkg::MAX_PARTS];
  logic [16:0] tbl_size[vpa_pkg::MAX_PARTS];
  logic        tbl_busy[vpa_pkg::MAX_PARTS];
  int          tbl_count;
  logic [16:0] mem_total = 17'd1024;
  logic        best_fit = 1'b0;

  variable_partition_allocator u_top (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void rebuild_table();
    for (int i = 0; i < vpa_pkg::MAX_PARTS; i++) begin
      tbl_start[i] = '0;
      tbl_size[i]  = '0;
      tbl_busy[i]  = 1'b0;
    end
    tbl_size[0] = mem_total;
    tbl_count   = 1;
  endfunction

  function automatic void drop_entry(int k);
    for (int i = k; i + 1 < tbl_count; i++) begin
      tbl_start[i] = tbl_start[i+1];
      tbl_size[i]  = tbl_size[i+1];
      tbl_busy[i]  = tbl_busy[i+1];
    end
    tbl_count--;
  endfunction

  function automatic result_t serve_word(word_t w);
    result_t r;
    int      pick;
    bit      found;
    int      k;
    r.status = vpa_pkg::ST_OK;
    r.addr   = '0;
    r.idx    = '0;
    pick     = 0;
    found    = 0;
    k        = int'(w.idx);
    if (w.op == vpa_pkg::OP_ALLOC) begin
      if (w.req == 0) begin
        r.status = vpa_pkg::ST_BADSIZE;
        return r;
      end
      for (int i = 0; i < tbl_count; i++) begin
        if (tbl_busy[i] || tbl_size[i] < w.req) continue;
        if (!found) begin
          pick  = i;
          found = 1;
          if (!best_fit) break;
        end else if (tbl_size[i] < tbl_size[pick]) pick = i;
      end
      if (!found) begin
        r.status = vpa_pkg::ST_NOFIT;
        return r;
      end
      if (tbl_size[pick] != w.req) begin
        if (tbl_count >= vpa_pkg::MAX_PARTS) begin
          r.status = vpa_pkg::ST_NOFIT;
          return r;
        end
        for (int i = tbl_count; i > pick; i--) begin
          tbl_start[i] = tbl_start[i-1];
          tbl_size[i]  = tbl_size[i-1];
          tbl_busy[i]  = tbl_busy[i-1];
        end
        tbl_count++;
        tbl_size[pick]    = w.req;
        tbl_start[pick+1] = tbl_start[pick] + w.req;
        tbl_size[pick+1]  = tbl_size[pick+1] - w.req;
        tbl_busy[pick+1]  = 1'b0;
      end
      tbl_busy[pick] = 1'b1;
      r.addr = tbl_start[pick];
      r.idx  = pick[5:0];
    end else begin
      if (k >= tbl_count) r.status = vpa_pkg::ST_NOPART;
      else if (!tbl_busy[k]) r.status = vpa_pkg::ST_ISFREE;
      else begin
        tbl_busy[k] = 1'b0;
        // merge left, then right
        if (k > 0 && !tbl_busy[k-1]) begin
          tbl_size[k-1] = tbl_size[k-1] + tbl_size[k];
          drop_entry(k);
          k--;
        end
        if (k + 1 < tbl_count && !tbl_busy[k+1]) begin
          tbl_size[k] = tbl_size[k] + tbl_size[k+1];
          drop_entry(k + 1);
        end
      end
    end
    return r;
  endfunction

  // sender
  always @(negedge clk) begin
    word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || taken) begin
      if (pending.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        w = pending.pop_front();
        in_valid           <= 1'b1;
        in_opcode          <= w.op;
        in_request_size    <= w.req;
        in_partition_index <= w.idx;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // accept words, check results
  always @(posedge clk) begin
    word_t   w;
    result_t e;
    taken <= in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      w.op  = in_opcode;
      w.req = in_request_size;
      w.idx = in_partition_index;
      expected.push_back(serve_word(w));
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result status %0d", out_status);
      end else begin
        e = expected.pop_front();
        if (out_status !== e.status || out_block_address !== e.addr ||
            out_block_index !== e.idx) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected st %0d addr %0d idx %0d, got st %0d addr %0d idx %0d",
                     e.status, e.addr, e.idx, out_status, out_block_address,
                     out_block_index);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic push_word(logic op, logic [16:0] req, logic [5:0] idx);
    word_t w;
    w.op  = op;
    w.req = req;
    w.idx = idx;
    pending.push_back(w);
  endtask

  task automatic write_reg(logic which, logic [16:0] value);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = which;
    cfg_data  = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (which == vpa_pkg::CFG_TOTAL) begin
      mem_total = value;
      rebuild_table();
    end else best_fit = value[0];
  endtask

  task automatic drain();
    while (pending.size() > 0 || in_valid || expected.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_words(int n, int span);
    int          pick;
    logic [16:0] sz;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) sz = 17'($urandom_range(1, 8));
      else if (pick < 50) sz = 17'($urandom_range(1, span));
      else if (pick < 54) sz = 17'($urandom_range(0, 17'h1FFFF));
      else if (pick < 56) sz = '0;
      if (pick < 56) push_word(vpa_pkg::OP_ALLOC, sz, 6'($urandom_range(0, 63)));
      else if (pick < 94)
        push_word(vpa_pkg::OP_FREE, 17'($urandom_range(0, 17'h1FFFF)),
                  6'($urandom_range(0, 20)));
      else
        push_word(vpa_pkg::OP_FREE, 17'($urandom_range(0, 17'h1FFFF)),
                  6'($urandom_range(0, 63)));
    end
  endtask

  initial begin
    logic [16:0] totals[8];
    logic        policies[8];
    int          span;
    totals   = '{17'd1024, 17'd1024, 17'h1FFFF, 17'd1, 17'd300, 17'h1FFFF, 17'd64, 17'd5000};
    policies = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
    rebuild_table();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset setting, 1024 units, first fit
    push_word(vpa_pkg::OP_ALLOC, 17'd0, 6'd0);
    push_word(vpa_pkg::OP_ALLOC, 17'h1FFFF, 6'd63);
    push_word(vpa_pkg::OP_ALLOC, 17'd1024, 6'd0);
    push_word(vpa_pkg::OP_ALLOC, 17'd1, 6'd0);
    push_word(vpa_pkg::OP_FREE, 17'd0, 6'd0);
    push_word(vpa_pkg::OP_FREE, 17'd0, 6'd0);
    push_word(vpa_pkg::OP_FREE, 17'h1FFFF, 6'd63);
    push_word(vpa_pkg::OP_ALLOC, 17'd100, 6'd0);
    push_word(vpa_pkg::OP_ALLOC, 17'd200, 6'd0);
    push_word(vpa_pkg::OP_ALLOC, 17'd300, 6'd0);
    push_word(vpa_pkg::OP_FREE, 17'd0, 6'd1);
    push_word(vpa_pkg::OP_ALLOC, 17'd50, 6'd0);
    push_word(vpa_pkg::OP_FREE, 17'd0, 6'd0);
    push_word(vpa_pkg::OP_FREE, 17'd0, 6'd3);
    push_word(vpa_pkg::OP_FREE, 17'd0, 6'd1);
    push_word(vpa_pkg::OP_FREE, 17'd0, 6'd2);
    push_word(vpa_pkg::OP_ALLOC, 17'd424, 6'd0);
    push_word(vpa_pkg::OP_FREE, 17'd0, 6'd1);
    push_word(vpa_pkg::OP_FREE, 17'd0, 6'd4);
    push_word(vpa_pkg::OP_FREE, 17'd0, 6'd0);
    drain();

    for (int p = 0; p < 8; p++) begin
      write_reg(vpa_pkg::CFG_TOTAL, totals[p]);
      write_reg(vpa_pkg::CFG_POLICY, {16'd0, policies[p]});
      span = (int'(totals[p]) > 16) ? int'(totals[p]) / 4 : int'(totals[p]) + 1;
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      // fill the table with unit blocks now and then to reach the full case
      if (p % 2 == 0) for (int i = 0; i < 66; i++) push_word(vpa_pkg::OP_ALLOC, 17'd1, 6'd0);
      random_words((p % 2 == 0) ? 150 : 216, span);
      drain();
      idle_pct  = 0;
      stall_pct = 0;
    end

    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
